[hdl/ulsup_pkg.sv]
// ----------------------------------------------------------------------------
// ulsup_pkg
// Shared types, codes and helpers for the uplink link supervisor.
// ----------------------------------------------------------------------------
package ulsup_pkg;

    localparam int TYPE_COUNT_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TIMEOUT_W  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSHAKEN = 3'd4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 20'd1000;
    localparam logic [7:0]           SAFE_RST     = 8'h01;
    localparam logic [7:0]           STALE_RST    = 8'h02;
    localparam logic [7:0]           MISMATCH_RST = 8'h04;
    localparam logic [7:0]           UNSHAKEN_RST = 8'h08;

    localparam logic [1:0] MODE_FRAME     = 2'd0;
    localparam logic [1:0] MODE_TICK      = 2'd1;
    localparam logic [1:0] MODE_RECONNECT = 2'd2;

    localparam int EV_W        = 10;
    localparam int EV_SAFE_IN   = 0;
    localparam int EV_SAFE_OUT  = 1;
    localparam int EV_STALE_IN  = 2;
    localparam int EV_STALE_OUT = 3;
    localparam int EV_HS_DONE   = 4;
    localparam int EV_HS_LOST   = 5;
    localparam int EV_MISMATCH  = 6;
    localparam int EV_LOST      = 7;
    localparam int EV_RESTORED  = 8;
    localparam int EV_RESTART   = 9;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  frame_type;
        logic [15:0] frame_seq;
        logic [31:0] remote_time;
        logic [7:0]  frame_status;
        logic [15:0] cmd_echo_in;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [EV_W-1:0] events;
        logic            any_event;
        logic            link_alive;
        logic [31:0]     gap_total;
        logic [31:0]     frame_total;
        logic [31:0]     reconnect_total;
        logic [15:0]     cmd_echo_out;
        logic [7:0]      status_out;
    } out_item_t;

    typedef struct packed {
        logic [7:0] safe;
        logic [7:0] stale;
        logic [7:0] mismatch;
        logic [7:0] unshaken;
    } mask_set_t;

    // sequence table operation for the request being retired
    typedef struct packed {
        logic        frame;
        logic        clear;
        logic [7:0]  frame_type;
        logic [15:0] frame_seq;
    } seq_op_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[hdl/ulsup_seq_track.sv]
// ----------------------------------------------------------------------------
// ulsup_seq_track
// Per-type sequence table with valid marks; yields the missing-frame count.
// ----------------------------------------------------------------------------
module ulsup_seq_track #(
    parameter int TYPE_COUNT = ulsup_pkg::TYPE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_req,
    input  logic [7:0]        rd_type,
    input  ulsup_pkg::seq_op_t op,
    output logic [15:0]       miss
);
    import ulsup_pkg::*;

    localparam int IDX_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam logic [8:0] TYPE_LIMIT = 9'(TYPE_COUNT);

    logic [15:0]           seq_mem [TYPE_COUNT];
    logic [15:0]           rd_data_reg;
    logic [TYPE_COUNT-1:0] seq_valid_reg;
    logic [TYPE_COUNT-1:0] seq_valid_next;
    logic [IDX_W-1:0]      op_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic                  in_range;
    logic                  wr_en;
    logic                  tracked;
    logic [15:0]           gap;

    assign op_idx   = op.frame_type[IDX_W-1:0];
    assign rd_idx   = rd_type[IDX_W-1:0];
    assign in_range = {1'b0, op.frame_type} < TYPE_LIMIT;
    assign wr_en    = op.frame && in_range;

    // write-through forwarding covers the request retiring on the read edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seq_mem[op_idx] <= op.frame_seq;
        end
        if (rd_req)
        begin
            if (wr_en && (op_idx == rd_idx))
            begin
                rd_data_reg <= op.frame_seq;
            end
            else
            begin
                rd_data_reg <= seq_mem[rd_idx];
            end
        end
    end

    always_comb
    begin
        seq_valid_next = op.clear ? '0 : seq_valid_reg;
        if (wr_en)
        begin
            seq_valid_next[op_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= '0;
        end
        else
        begin
            seq_valid_reg <= seq_valid_next;
        end
    end

    assign tracked = in_range && !op.clear && seq_valid_reg[op_idx];
    assign gap     = op.frame_seq - rd_data_reg;
    assign miss    = (tracked && (gap > 16'd1)) ? (gap - 16'd1) : 16'd0;

endmodule

[hdl/ulsup_edges.sv]
// ----------------------------------------------------------------------------
// ulsup_edges
// Rising/falling detection of the masked remote status groups.
// ----------------------------------------------------------------------------
module ulsup_edges (
    input  logic [7:0]              prev,
    input  logic [7:0]              now,
    input  logic                    first,
    input  ulsup_pkg::mask_set_t    masks,
    output logic [ulsup_pkg::EV_W-1:0] events
);
    import ulsup_pkg::*;

    logic p_safe, n_safe, p_stale, n_stale, p_mis, n_mis, p_hs, n_hs;

    assign p_safe  = |(prev & masks.safe);
    assign n_safe  = |(now & masks.safe);
    assign p_stale = |(prev & masks.stale);
    assign n_stale = |(now & masks.stale);
    assign p_mis   = |(prev & masks.mismatch);
    assign n_mis   = |(now & masks.mismatch);
    assign p_hs    = |(prev & masks.unshaken);
    assign n_hs    = |(now & masks.unshaken);

    always_comb
    begin
        events               = '0;
        events[EV_SAFE_IN]   = n_safe && !p_safe;
        events[EV_SAFE_OUT]  = !n_safe && p_safe;
        events[EV_STALE_IN]  = n_stale && !p_stale;
        events[EV_STALE_OUT] = !n_stale && p_stale;
        events[EV_MISMATCH]  = n_mis && !p_mis;
        events[EV_HS_LOST]   = n_hs && !p_hs;
        // first frame already handshaked counts as done
        events[EV_HS_DONE]   = (!n_hs && p_hs) || (first && !n_hs);
    end

endmodule

[hdl/uplink_link_supervisor.sv]
// ----------------------------------------------------------------------------
// uplink_link_supervisor
// Uplink supervision: restart, sequence gaps, status edges, loss, reconnect.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the input register, single-pass logic and
// then the result register.
// Throughput: one request per cycle; the input register advances whenever
// the result register is empty or being taken.
// Reset: async, active low; config returns to defaults, counters and link
// state clear, sequence marks invalidate at once.
module uplink_link_supervisor #(
    parameter int TYPE_COUNT = ulsup_pkg::TYPE_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ulsup_pkg::in_item_t                 in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ulsup_pkg::out_item_t                out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ulsup_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ulsup_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ulsup_pkg::*;

    // configuration
    logic [TIMEOUT_W-1:0] timeout_reg;
    mask_set_t            masks_reg;

    // pipeline
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      s1_adv;
    logic      proc;

    // link state
    logic [7:0]  status_reg,       status_next;
    logic        seen_reg,         seen_next;
    logic        alive_reg,        alive_next;
    logic        tvalid_reg,       tvalid_next;
    logic [31:0] last_rtime_reg,   last_rtime_next;
    logic [15:0] cmd_echo_reg,     cmd_echo_next;
    logic [31:0] last_ftime_reg,   last_ftime_next;
    logic [31:0] gap_cnt_reg,      gap_cnt_next;
    logic [31:0] frame_cnt_reg,    frame_cnt_next;
    logic [31:0] recon_cnt_reg,    recon_cnt_next;

    logic [EV_W-1:0] ev;
    logic [EV_W-1:0] edge_ev;
    logic [7:0]      prev_status;
    logic            restart;
    logic            lost;
    logic [31:0]     elapsed;
    logic [15:0]     miss;
    seq_op_t         seq_op;
    out_item_t       res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg        <= TIMEOUT_RST;
            masks_reg.safe     <= SAFE_RST;
            masks_reg.stale    <= STALE_RST;
            masks_reg.mismatch <= MISMATCH_RST;
            masks_reg.unshaken <= UNSHAKEN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT:  timeout_reg        <= cfg_data[TIMEOUT_W-1:0];
                CFG_SAFE:     masks_reg.safe     <= cfg_data[7:0];
                CFG_STALE:    masks_reg.stale    <= cfg_data[7:0];
                CFG_MISMATCH: masks_reg.mismatch <= cfg_data[7:0];
                CFG_UNSHAKEN: masks_reg.unshaken <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    assign s1_adv    = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign proc      = s1_valid_reg && s1_adv;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (proc)
        begin
            out_item_reg <= res;
        end
    end

    assign restart     = tvalid_reg && (s1_item_reg.remote_time < last_rtime_reg);
    assign elapsed     = s1_item_reg.now_ms - last_ftime_reg;
    assign lost        = alive_reg && (elapsed > {12'd0, timeout_reg});
    assign prev_status = seen_reg ? status_reg : masks_reg.unshaken;

    ulsup_edges u_edges (
        .prev   (prev_status),
        .now    (s1_item_reg.frame_status),
        .first  (!seen_reg),
        .masks  (masks_reg),
        .events (edge_ev)
    );

    always_comb
    begin
        seq_op.frame      = proc && (s1_item_reg.mode == MODE_FRAME);
        seq_op.clear      = 1'b0;
        seq_op.frame_type = s1_item_reg.frame_type;
        seq_op.frame_seq  = s1_item_reg.frame_seq;
        if (proc)
        begin
            case (s1_item_reg.mode)
                MODE_FRAME:     seq_op.clear = restart;
                MODE_TICK:      seq_op.clear = lost;
                MODE_RECONNECT: seq_op.clear = 1'b1;
                default:        seq_op.clear = 1'b0;
            endcase
        end
    end

    ulsup_seq_track #(
        .TYPE_COUNT (TYPE_COUNT)
    ) u_seq_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_req  (in_valid && in_ready),
        .rd_type (in_item.frame_type),
        .op      (seq_op),
        .miss    (miss)
    );

    always_comb
    begin
        ev              = '0;
        status_next     = status_reg;
        seen_next       = seen_reg;
        alive_next      = alive_reg;
        tvalid_next     = tvalid_reg;
        last_rtime_next = last_rtime_reg;
        cmd_echo_next   = cmd_echo_reg;
        last_ftime_next = last_ftime_reg;
        gap_cnt_next    = gap_cnt_reg;
        frame_cnt_next  = frame_cnt_reg;
        recon_cnt_next  = recon_cnt_reg;
        case (s1_item_reg.mode)
            MODE_FRAME:
            begin
                ev                 = edge_ev;
                ev[EV_RESTART]     = restart;
                ev[EV_RESTORED]    = !alive_reg && seen_reg;
                tvalid_next        = 1'b1;
                last_rtime_next    = s1_item_reg.remote_time;
                gap_cnt_next       = sat_add32(gap_cnt_reg, {16'd0, miss});
                frame_cnt_next     = sat_add32(frame_cnt_reg, 32'd1);
                cmd_echo_next      = s1_item_reg.cmd_echo_in;
                last_ftime_next    = s1_item_reg.now_ms;
                alive_next         = 1'b1;
                status_next        = s1_item_reg.frame_status;
                seen_next          = 1'b1;
            end
            MODE_TICK:
            begin
                if (lost)
                begin
                    ev[EV_LOST] = 1'b1;
                    alive_next  = 1'b0;
                    status_next = masks_reg.unshaken;
                    tvalid_next = 1'b0;
                end
            end
            MODE_RECONNECT:
            begin
                status_next     = masks_reg.unshaken;
                seen_next       = 1'b0;
                alive_next      = 1'b0;
                tvalid_next     = 1'b0;
                cmd_echo_next   = 16'd0;
                last_ftime_next = s1_item_reg.now_ms;
                recon_cnt_next  = sat_add32(recon_cnt_reg, 32'd1);
            end
            default: ;
        endcase

        res.events          = ev;
        res.any_event       = |ev;
        res.link_alive      = alive_next;
        res.gap_total       = gap_cnt_next;
        res.frame_total     = frame_cnt_next;
        res.reconnect_total = recon_cnt_next;
        res.cmd_echo_out    = cmd_echo_next;
        res.status_out      = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= UNSHAKEN_RST;
            seen_reg       <= 1'b0;
            alive_reg      <= 1'b0;
            tvalid_reg     <= 1'b0;
            last_rtime_reg <= '0;
            cmd_echo_reg   <= '0;
            last_ftime_reg <= '0;
            gap_cnt_reg    <= '0;
            frame_cnt_reg  <= '0;
            recon_cnt_reg  <= '0;
        end
        else if (proc)
        begin
            status_reg     <= status_next;
            seen_reg       <= seen_next;
            alive_reg      <= alive_next;
            tvalid_reg     <= tvalid_next;
            last_rtime_reg <= last_rtime_next;
            cmd_echo_reg   <= cmd_echo_next;
            last_ftime_reg <= last_ftime_next;
            gap_cnt_reg    <= gap_cnt_next;
            frame_cnt_reg  <= frame_cnt_next;
            recon_cnt_reg  <= recon_cnt_next;
        end
    end

    // reconnect reports nothing and leaves the link down
    a_recon_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        proc && (s1_item_reg.mode == MODE_RECONNECT)
        |=> (out_item.events == '0) && !out_item.link_alive)
        else $error("reconnect result carries events or live link");

    // loss forces the link down and status to not-handshaked
    a_lost_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.events[EV_LOST]
        |-> !out_item.link_alive && (out_item.status_out == masks_reg.unshaken))
        else $error("loss reported without forced status");

    // saturating counters never move backward
    a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_cnt_reg >= $past(frame_cnt_reg)) && (gap_cnt_reg >= $past(gap_cnt_reg)))
        else $error("counter decreased");

endmodule

[bench/uplink_link_supervisor_tb.sv]
// ----------------------------------------------------------------------------
// uplink_link_supervisor_tb
// Self-checking bench for the uplink link supervisor.
// A short directed run covers first-frame handshake, sequence gaps and
// wraps, remote restart, loss on timeout, restore, reconnect and the unused
// mode. Random phases follow under changing masks and timeouts, with random
// stalls on both channels, one long output hold-off and a burst of backward
// sequence steps that adds large gap counts. Every result is compared field
// by field with an in-bench model of the supervisor.
// ----------------------------------------------------------------------------
module uplink_link_supervisor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ulsup_pkg::*;

    localparam int N_TYPES = TYPE_COUNT_DEF;
    localparam int TYPE_IDX_W = $clog2(N_TYPES);
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_LEN = 210;
    localparam int BURST_FRAMES = 20;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    in_item_t  request_q[$];
    out_item_t expected_q[$];

    int errors = 0;
    int quiet = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_ask = 0;
    int hold_seen = 0;

    // supervisor model: configuration and link state
    logic [19:0] m_timeout = TIMEOUT_RST;
    logic [7:0]  m_safe = SAFE_RST;
    logic [7:0]  m_stale = STALE_RST;
    logic [7:0]  m_mismatch = MISMATCH_RST;
    logic [7:0]  m_unshaken = UNSHAKEN_RST;
    logic [7:0]  m_status = UNSHAKEN_RST;
    logic        m_seen = 1'b0;
    logic        m_alive = 1'b0;
    logic        m_time_ok = 1'b0;
    logic [31:0] m_last_rtime = '0;
    logic [15:0] m_seq [N_TYPES] = '{default: 16'h0000};
    logic [N_TYPES-1:0] m_seq_ok = '0;
    logic [15:0] m_echo = '0;
    logic [31:0] m_last_ftime = '0;
    logic [31:0] m_gaps = '0;
    logic [31:0] m_frames = '0;
    logic [31:0] m_reconnects = '0;

    // request generator state
    logic [31:0] gen_now = 32'hFFFF_F000;
    logic [31:0] gen_rtime = 32'd1000;
    logic [15:0] gen_seq [N_TYPES] = '{default: 16'h0000};
    logic [7:0]  gen_status = 8'h00;
    int          gen_timeout = int'(TIMEOUT_RST);

    uplink_link_supervisor i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
    endfunction

    // {rise, fall} of a masked status group
    function automatic logic [1:0] level_change(input logic [7:0] was, input logic [7:0] is_now,
                                                input logic [7:0] m);
        logic p;
        logic n;
        p = |(was & m);
        n = |(is_now & m);
        return {n & ~p, p & ~n};
    endfunction

    function automatic out_item_t supervise(input in_item_t req);
        out_item_t             res;
        logic [EV_W-1:0]       ev;
        logic [7:0]            prior;
        logic [15:0]           seq_step;
        logic [31:0]           elapsed;
        logic [1:0]            chg;
        logic [TYPE_IDX_W-1:0] t;
        ev = '0;
        case (req.mode)
            MODE_FRAME:
            begin
                if (m_time_ok && req.remote_time < m_last_rtime)
                begin
                    ev[EV_RESTART] = 1'b1;
                    m_seq_ok = '0;
                end
                m_time_ok = 1'b1;
                m_last_rtime = req.remote_time;
                if (int'(req.frame_type) < N_TYPES)
                begin
                    t = req.frame_type[TYPE_IDX_W-1:0];
                    if (m_seq_ok[t])
                    begin
                        seq_step = req.frame_seq - m_seq[t];
                        if (seq_step > 16'd1)
                            m_gaps = sat_sum(m_gaps, {16'd0, seq_step} - 32'd1);
                    end
                    m_seq[t] = req.frame_seq;
                    m_seq_ok[t] = 1'b1;
                end
                m_frames = sat_sum(m_frames, 32'd1);
                m_echo = req.cmd_echo_in;
                m_last_ftime = req.now_ms;
                if (!m_alive)
                begin
                    ev[EV_RESTORED] = m_seen;
                    m_alive = 1'b1;
                end
                prior = m_seen ? m_status : m_unshaken;
                chg = level_change(prior, req.frame_status, m_safe);
                ev[EV_SAFE_IN] = chg[1];
                ev[EV_SAFE_OUT] = chg[0];
                chg = level_change(prior, req.frame_status, m_stale);
                ev[EV_STALE_IN] = chg[1];
                ev[EV_STALE_OUT] = chg[0];
                chg = level_change(prior, req.frame_status, m_mismatch);
                ev[EV_MISMATCH] = chg[1];
                chg = level_change(prior, req.frame_status, m_unshaken);
                ev[EV_HS_LOST] = chg[1];
                ev[EV_HS_DONE] = chg[0];
                if (!m_seen && (req.frame_status & m_unshaken) == 8'h00)
                    ev[EV_HS_DONE] = 1'b1;
                m_status = req.frame_status;
                m_seen = 1'b1;
            end
            MODE_TICK:
            begin
                elapsed = req.now_ms - m_last_ftime;
                if (m_alive && elapsed > {12'd0, m_timeout})
                begin
                    m_alive = 1'b0;
                    m_status = m_unshaken;
                    m_seq_ok = '0;
                    m_time_ok = 1'b0;
                    ev[EV_LOST] = 1'b1;
                end
            end
            MODE_RECONNECT:
            begin
                m_status = m_unshaken;
                m_seen = 1'b0;
                m_alive = 1'b0;
                m_seq_ok = '0;
                m_time_ok = 1'b0;
                m_echo = '0;
                m_last_ftime = req.now_ms;
                m_reconnects = sat_sum(m_reconnects, 32'd1);
            end
            default: ;
        endcase
        res.events = ev;
        res.any_event = |ev;
        res.link_alive = m_alive;
        res.gap_total = m_gaps;
        res.frame_total = m_frames;
        res.reconnect_total = m_reconnects;
        res.cmd_echo_out = m_echo;
        res.status_out = m_status;
        return res;
    endfunction

    task automatic flag(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    function automatic int draw_wait(input int pct);
        return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 8) : 0;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] mode, input logic [7:0] ftype,
                                           input logic [15:0] seq, input logic [31:0] rtime,
                                           input logic [7:0] status, input logic [15:0] echo,
                                           input logic [31:0] stamp);
        in_item_t req;
        req.mode = mode;
        req.frame_type = ftype;
        req.frame_seq = seq;
        req.remote_time = rtime;
        req.frame_status = status;
        req.cmd_echo_in = echo;
        req.now_ms = stamp;
        return req;
    endfunction

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return 8'd1 << $urandom_range(0, 7);
            1: return 8'($urandom());
            2: return 8'd3 << $urandom_range(0, 6);
            default: return 8'h00;
        endcase
    endfunction

    // mostly ordered frames per type, with ticks, reconnects and noise
    function automatic in_item_t random_request();
        in_item_t              req;
        int                    roll;
        logic [TYPE_IDX_W-1:0] t;
        req = make_item(MODE_FRAME, 8'($urandom()), 16'($urandom()), $urandom(),
                        8'($urandom()), 16'($urandom()), 32'h0);
        gen_now = gen_now + $urandom_range(0, gen_timeout / 8 + 3);
        if ($urandom_range(0, 49) == 0)
            gen_now = $urandom();
        req.now_ms = gen_now;
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            req.mode = MODE_UNUSED;
            req.now_ms = $urandom();
        end
        else if (roll < 7)
            req.mode = MODE_RECONNECT;
        else if (roll < 25)
        begin
            req.mode = MODE_TICK;
            if ($urandom_range(0, 3) == 0)
                gen_now = gen_now + gen_timeout + $urandom_range(0, 2) - 1;
            req.now_ms = gen_now;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                req.frame_type = 8'($urandom_range(0, 3));
            else if (roll < 85)
                req.frame_type = 8'($urandom_range(0, N_TYPES - 1));
            else
                req.frame_type = 8'($urandom_range(N_TYPES, 255));
            if (int'(req.frame_type) < N_TYPES)
            begin
                t = req.frame_type[TYPE_IDX_W-1:0];
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    gen_seq[t] = gen_seq[t] + 16'd1;
                else if (roll < 65)
                    gen_seq[t] = gen_seq[t];
                else if (roll < 80)
                    gen_seq[t] = gen_seq[t] + 16'($urandom_range(2, 6));
                else if (roll < 92)
                    gen_seq[t] = 16'($urandom());
                else
                    gen_seq[t] = gen_seq[t] - 16'd1;
                req.frame_seq = gen_seq[t];
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                gen_rtime = gen_rtime - $urandom_range(1, 5000);
            else if (roll < 5)
                gen_rtime = $urandom();
            else
                gen_rtime = gen_rtime + $urandom_range(0, 40);
            req.remote_time = gen_rtime;
            if ($urandom_range(0, 99) < 35)
                gen_status = $urandom_range(0, 1) ? 8'($urandom())
                                                  : gen_status ^ (8'd1 << $urandom_range(0, 7));
            req.frame_status = gen_status;
        end
        return req;
    endfunction

    task automatic drain();
        while (request_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_TIMEOUT: m_timeout = value[19:0];
            CFG_SAFE: m_safe = value[7:0];
            CFG_STALE: m_stale = value[7:0];
            CFG_MISMATCH: m_mismatch = value[7:0];
            CFG_UNSHAKEN: m_unshaken = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int timeout, input logic [7:0] safe, input logic [7:0] stale,
                              input logic [7:0] mismatch, input logic [7:0] unshaken);
        write_reg(CFG_TIMEOUT, 32'(timeout));
        write_reg(CFG_SAFE, {24'd0, safe});
        write_reg(CFG_STALE, {24'd0, stale});
        write_reg(CFG_MISMATCH, {24'd0, mismatch});
        write_reg(CFG_UNSHAKEN, {24'd0, unshaken});
        cfg_valid <= 1'b0;
        gen_timeout = timeout;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(supervise(in_item));
                send_wait = draw_wait(send_idle_pct);
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    in_item <= request_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    flag($sformatf("result with no request outstanding, events %h",
                                   out_item.events));
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("events", 32'(out_item.events), 32'(want.events));
                    compare_field("any_event", 32'(out_item.any_event), 32'(want.any_event));
                    compare_field("link_alive", 32'(out_item.link_alive),
                                  32'(want.link_alive));
                    compare_field("gap_total", out_item.gap_total, want.gap_total);
                    compare_field("frame_total", out_item.frame_total, want.frame_total);
                    compare_field("reconnect_total", out_item.reconnect_total,
                                  want.reconnect_total);
                    compare_field("cmd_echo_out", 32'(out_item.cmd_echo_out),
                                  32'(want.cmd_echo_out));
                    compare_field("status_out", 32'(out_item.status_out),
                                  32'(want.status_out));
                end
                recv_wait = draw_wait(recv_idle_pct);
            end
            if (hold_seen != hold_ask)
            begin
                hold_seen = hold_ask;
                recv_wait = LONG_HOLD;
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        request_q.push_back(make_item(MODE_TICK, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0, 32'd50));
        request_q.push_back(make_item(MODE_FRAME, 8'd0, 16'h0000, 32'd100, 8'h00, 16'h1234,
                                      32'd100));
        request_q.push_back(make_item(MODE_FRAME, 8'd0, 16'h0001, 32'd110, 8'h01, 16'h0,
                                      32'd110));
        request_q.push_back(make_item(MODE_FRAME, 8'd0, 16'h0001, 32'd110, 8'h03, 16'h1,
                                      32'd120));
        request_q.push_back(make_item(MODE_FRAME, 8'd0, 16'h0005, 32'd120, 8'h04, 16'h2,
                                      32'd130));
        request_q.push_back(make_item(MODE_FRAME, 8'd0, 16'hFFFF, 32'd130, 8'h0C, 16'h3,
                                      32'd140));
        request_q.push_back(make_item(MODE_FRAME, 8'd15, 16'hFFFF, 32'd140, 8'h00, 16'h4,
                                      32'd150));
        request_q.push_back(make_item(MODE_FRAME, 8'd16, 16'h8000, 32'd150, 8'h00, 16'h5,
                                      32'd160));
        request_q.push_back(make_item(MODE_FRAME, 8'd255, 16'hFFFF, 32'd160, 8'h00, 16'h6,
                                      32'd170));
        // timestamp goes backward: remote restart
        request_q.push_back(make_item(MODE_FRAME, 8'd0, 16'h0000, 32'd20, 8'h00, 16'h7,
                                      32'd190));
        request_q.push_back(make_item(MODE_FRAME, 8'd15, 16'h0003, 32'd30, 8'h00, 16'h8,
                                      32'd200));
        request_q.push_back(make_item(MODE_TICK, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0, 32'd1200));
        request_q.push_back(make_item(MODE_TICK, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0, 32'd1201));
        request_q.push_back(make_item(MODE_FRAME, 8'd1, 16'h0000, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF,
                                      32'hFFFF_FFFF));
        // elapsed time wraps through zero
        request_q.push_back(make_item(MODE_TICK, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0,
                                      32'h0000_07CF));
        request_q.push_back(make_item(MODE_RECONNECT, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0,
                                      32'h10));
        request_q.push_back(make_item(MODE_FRAME, 8'd2, 16'h0007, 32'd5, 8'h08, 16'h0001,
                                      32'h20));
        request_q.push_back(make_item(MODE_FRAME, 8'd2, 16'h0008, 32'd6, 8'h00, 16'h0002,
                                      32'h30));
        request_q.push_back(make_item(MODE_TICK, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0, 32'h40));
        request_q.push_back(make_item(MODE_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF,
                                      16'hFFFF, 32'hFFFF_FFFF));
        request_q.push_back(make_item(MODE_FRAME, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0, 32'h0));
        request_q.push_back(make_item(MODE_RECONNECT, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF,
                                      16'hFFFF, 32'hFFFF_FFFF));
        request_q.push_back(make_item(MODE_FRAME, 8'h80, 16'h5555, 32'hAAAA_AAAA, 8'h55,
                                      16'hAAAA, 32'h5555_5555));
        drain();

        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_config(1, 8'h00, 8'h00, 8'h00, 8'h00);
                1: set_config(1000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                6: set_config(int'(TIMEOUT_RST), SAFE_RST, STALE_RST, MISMATCH_RST,
                              UNSHAKEN_RST);
                default: set_config($urandom_range(1, 300), pick_mask(), pick_mask(),
                                    pick_mask(), pick_mask());
            endcase
            send_idle_pct = (phase == 0 || phase == 3) ? 0 : $urandom_range(0, 3) * 33;
            recv_idle_pct = (phase == 0) ? 0 : $urandom_range(0, 3) * 33;
            // receiver holds off while the sender keeps offering
            if (phase == 3)
                hold_ask++;
            repeat (PHASE_LEN) request_q.push_back(random_request());
            drain();
        end

        // steps of minus one add 65534 missing frames each
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < BURST_FRAMES; k++)
            request_q.push_back(make_item(MODE_FRAME, 8'd0, gen_seq[0] - 16'(k), gen_rtime,
                                          gen_status, 16'(k), gen_now));
        repeat (20) request_q.push_back(random_request());
        drain();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
hdl/ulsup_pkg.sv
hdl/ulsup_seq_track.sv
hdl/ulsup_edges.sv
hdl/uplink_link_supervisor.sv
bench/uplink_link_supervisor_tb.sv
